// ===== rtl/sector_cache_lru_tags_macros.svh =====
// assertion macros for the sector cache tag manager checker
// expects i_clk and i_rst_n in the scope of use
`ifndef SECTOR_CACHE_LRU_TAGS_MACROS_SVH
`define SECTOR_CACHE_LRU_TAGS_MACROS_SVH

// same-cycle implication, muted during reset
`define SCLT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, muted during reset
`define SCLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sclt_pkg.sv =====
// shared types and constants for the sector cache tag manager
// no dependencies
package sclt_pkg;

    localparam int          SLOTS_DEF      = 8;
    localparam int          IDX_W          = 6;    // covers up to 64 slots
    localparam logic [31:0] IDLE_LIMIT_RST = 32'd500;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_CHECK  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DONE
    } t_state;

    // search record handed from cell to cell
    typedef struct packed {
        logic             go;
        logic             found;
        logic             inval;
        logic             have;
        logic [IDX_W-1:0] idx;
        logic [31:0]      stamp;
    } t_carry;

    // update broadcast to every cell
    typedef struct packed {
        logic             wr;
        logic             fill;
        logic             vld;
        logic             drop;
        logic [IDX_W-1:0] idx;
        logic [31:0]      stamp;
    } t_upd;

    typedef struct packed {
        logic       dropped;
        logic       ok;
        logic       fetch;
        logic [2:0] slot;
        logic       hit;
    } t_res;

endpackage

// ===== rtl/sclt_cell.sv =====
// one slot of the tag chain: valid, tag and stamp plus one stage of the search
// depends on sclt_pkg
module sclt_cell #(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [31:0]       i_addr,
    input  sclt_pkg::t_carry  i_carry,
    input  sclt_pkg::t_upd    i_upd,
    output sclt_pkg::t_carry  o_carry
);
    import sclt_pkg::*;

    logic        r_valid;
    logic [31:0] r_tag;
    logic [31:0] r_stamp;
    t_carry      r_carry;
    t_carry      n_carry;
    logic        w_sel;

    assign w_sel = i_upd.wr && (i_upd.idx == IDX_W'(IDX));

    always_comb begin
        n_carry = i_carry;
        if (!i_carry.found) begin
            if (r_valid && (r_tag == i_addr)) begin
                n_carry.found = 1'b1;
                n_carry.idx   = IDX_W'(IDX);
            end else if (!i_carry.inval) begin
                if (!r_valid) begin
                    // first free slot wins outright
                    n_carry.inval = 1'b1;
                    n_carry.have  = 1'b1;
                    n_carry.idx   = IDX_W'(IDX);
                end else if (!i_carry.have || (r_stamp < i_carry.stamp)) begin
                    n_carry.have  = 1'b1;
                    n_carry.idx   = IDX_W'(IDX);
                    n_carry.stamp = r_stamp;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_carry <= '0;
        end else begin
            r_carry <= n_carry;
            if (i_upd.drop) begin
                r_valid <= 1'b0;
            end else if (w_sel && i_upd.fill) begin
                r_valid <= i_upd.vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_stamp <= i_upd.stamp;
            if (i_upd.fill) begin
                r_tag <= i_addr;
            end
        end
    end

    assign o_carry = r_carry;

endmodule

// ===== rtl/sector_cache_lru_tags.sv =====
// top level of the sector cache tag manager: control, chain of slot cells, output word
// depends on sclt_pkg and sclt_cell
//
// usage
//   input stream s_axis: one word per request; tuser selects lookup (0) or media check (1)
//   output stream m_axis: exactly one result word per request, in request order
//   config: i_cfg_we/i_cfg_wdata write the idle limit; the user must write it only
//   while the block is idle; the block has no check of its own for this
// flow
//   a lookup walks a search record down the chain of SLOTS cells, one cell per cycle,
//   then the last cell's record sets r_res, which ST_DONE moves to the output register
//   a media check sets r_res in ST_CHECK, which ST_DONE moves to the output register
//   one request is worked on at a time: the next one is taken in ST_IDLE once ST_DONE
//   has loaded the result; s_axis_tready is high only while no request is in progress
// stalls
//   the result sits in an output register; the next request can be taken while it
//   waits, and a finished result is held back until that register is free
// reset
//   synchronous, active low: all slots invalid, use clock, generation, touched flag
//   and last read tick cleared, idle limit back to 500; no clearing pass needed
module sector_cache_lru_tags #(
    parameter int SLOTS = sclt_pkg::SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // config
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    // request stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [103:0]  s_axis_tdata,  // block_addr[31:0] read_ok[32] disc_gen[64:33]
                                         // now[96:65], zero pad above
    input  logic          s_axis_tuser,  // action
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata   // hit[0] slot[3:1] fetch[4] ok[5] dropped[6]
                                         // zero pad above
);
    import sclt_pkg::*;

    t_state      r_state;
    t_state      n_state;

    // latched request
    logic [31:0] r_addr;
    logic        r_rd_ok;
    logic [31:0] r_gen;
    logic [31:0] r_now;

    // block state
    logic [31:0] r_use_clock;
    logic [31:0] r_known_gen;
    logic        r_touched;
    logic [31:0] r_last_read;
    logic [31:0] r_idle_limit;

    logic        r_launch;
    t_res        r_res;
    logic        r_out_valid;
    t_res        r_out;

    t_carry      w_carry [SLOTS+1];
    t_upd        w_upd;
    t_carry      w_fin;
    logic        w_s_acc;
    logic        w_load_out;
    logic        w_scan_end;
    logic        w_drop;
    logic [31:0] w_elapsed;

    assign w_s_acc    = s_axis_tvalid && s_axis_tready;
    assign w_fin      = w_carry[SLOTS];
    assign w_scan_end = (r_state == ST_SCAN) && w_fin.go;

    // idle test wraps modulo 2^32
    assign w_elapsed = r_now - r_last_read;
    assign w_drop    = (r_gen != r_known_gen) || (r_touched && (w_elapsed > r_idle_limit));

    // search record enters cell 0 the cycle after a lookup is taken
    always_comb begin
        w_carry[0]    = '0;
        w_carry[0].go = r_launch;
    end

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            sclt_cell #(
                .IDX (g)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_addr  (r_addr),
                .i_carry (w_carry[g]),
                .i_upd   (w_upd),
                .o_carry (w_carry[g+1])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    n_state = (s_axis_tuser == ACT_CHECK) ? ST_CHECK : ST_SCAN;
                end
            end
            ST_CHECK: begin
                n_state = ST_DONE;
            end
            ST_SCAN: begin
                if (w_fin.go) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_load_out    = 1'b0;
        w_upd         = '0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_CHECK: begin
                w_upd.drop = w_drop;
            end
            ST_SCAN: begin
                // hit restamps; miss refills and leaves the slot invalid on a failed read
                w_upd.wr    = w_fin.go;
                w_upd.idx   = w_fin.idx;
                w_upd.fill  = !w_fin.found;
                w_upd.vld   = w_fin.found || r_rd_ok;
                w_upd.stamp = r_use_clock;
            end
            ST_DONE: begin
                w_load_out = !r_out_valid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_use_clock  <= '0;
            r_known_gen  <= '0;
            r_touched    <= 1'b0;
            r_last_read  <= '0;
            r_idle_limit <= IDLE_LIMIT_RST;
            r_launch     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_launch <= w_s_acc && (s_axis_tuser == ACT_LOOKUP);
            if (i_cfg_we) begin
                r_idle_limit <= i_cfg_wdata;
            end
            if (w_s_acc && (s_axis_tuser == ACT_LOOKUP)) begin
                r_use_clock <= r_use_clock + 32'd1;
            end
            if (r_state == ST_CHECK) begin
                r_known_gen <= r_gen;
                if (w_drop) begin
                    r_touched <= 1'b0;
                end
            end
            if (w_scan_end && !w_fin.found) begin
                r_touched   <= 1'b1;
                r_last_read <= r_now;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_addr  <= s_axis_tdata[31:0];
            r_rd_ok <= s_axis_tdata[32];
            r_gen   <= s_axis_tdata[64:33];
            r_now   <= s_axis_tdata[96:65];
        end
        if (r_state == ST_CHECK) begin
            r_res.hit     <= 1'b0;
            r_res.slot    <= 3'd0;
            r_res.fetch   <= 1'b0;
            r_res.ok      <= 1'b1;
            r_res.dropped <= w_drop;
        end
        if (w_scan_end) begin
            r_res.hit     <= w_fin.found;
            r_res.slot    <= w_fin.idx[2:0];
            r_res.fetch   <= !w_fin.found;
            r_res.ok      <= w_fin.found || r_rd_ok;
            r_res.dropped <= 1'b0;
        end
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.dropped, r_out.ok, r_out.fetch, r_out.slot, r_out.hit};

endmodule

// ===== rtl/sclt_checker.sv =====
// port-level checks for the sector cache tag manager, bound to the top level
// depends on sector_cache_lru_tags_macros.svh
`include "sector_cache_lru_tags_macros.svh"

module sclt_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [7:0]    m_axis_tdata
);

    // a stalled result word keeps its contents
    `SCLT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")

    // a hit never issues a read and always reports ok
    `SCLT_ASSERT_NOW(a_hit_no_fetch, m_axis_tvalid && m_axis_tdata[0], !m_axis_tdata[4] && m_axis_tdata[5], "hit with fetch or failure")

    // a failure can only come from a fill read
    `SCLT_ASSERT_NOW(a_fail_needs_fetch, m_axis_tvalid && !m_axis_tdata[5], m_axis_tdata[4] && !m_axis_tdata[0], "failure without fetch")

    // a drop comes from a media check, which sets ok and no lookup field
    `SCLT_ASSERT_NOW(a_drop_clean, m_axis_tvalid && m_axis_tdata[6], m_axis_tdata[5:0] == 6'b100000, "drop mixed with lookup fields")

    // a request taken closes the input until its work is done
    `SCLT_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second request taken at once")

endmodule

bind sector_cache_lru_tags sclt_checker u_sclt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
